/* sv/assert_macros.svh */
// Assertion macros shared by the grouper RTL.
// Every check is sampled on clock and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CFPG_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define CFPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/cfpg_pkg.sv */
// Package for the conflict-free process grouper.
// Holds the payload structs, fixed field widths and controller/datapath links.
package cfpg_pkg;

   localparam int ID_W        = 16;
   localparam int MASK_W      = 64;
   localparam int GRP_W       = 5;
   localparam int MAX_RESULTS = 32;
   localparam int RES_CNT_W   = 6;

   // One incoming process record
   typedef struct packed {
      logic [ID_W-1:0]   proc_tag;
      logic [MASK_W-1:0] read_mask;
      logic [MASK_W-1:0] write_mask;
      logic              last_process;
   } req_type;

   // One partition member result
   typedef struct packed {
      logic [GRP_W-1:0] group_id;
      logic [ID_W-1:0]  member_id;
      logic             group_end;
      logic             run_end;
      logic             overflowed;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic skip;
      logic open;
      logic scan;
      logic end_group;
      logic finish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic i_done;
      logic i_marked;
      logic scan_done;
      logic res_full;
      logic out_free;
   } sts_type;

endpackage

/* sv/cfpg_ctrl.sv */
// Sequencer for the grouper: load, pick group seed, scan, drain.
// Depends on cfpg_pkg for command and status structs.
module cfpg_ctrl import cfpg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_NEXT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_LOAD);

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if (sts.i_done || sts.res_full) begin
               state_in = ST_FINISH;
            end else if (sts.i_marked) begin
               cmd.skip = 1'b1;
            end else begin
               cmd.open = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.res_full) begin
               state_in = ST_FINISH;
            end else if (sts.scan_done) begin
               cmd.end_group = 1'b1;
               state_in      = ST_NEXT;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            if (sts.out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/cfpg_datapath.sv */
// Datapath for the grouper: record stores, assigned marks, group unions,
// pending result and output register. Depends on cfpg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfpg_datapath import cfpg_pkg::*; #(
   parameter int MAX_PROCS   = 32,
   parameter int NUM_SIGNALS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int IW = $clog2(MAX_PROCS);
   localparam int NS = NUM_SIGNALS;
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_PROCS);
   localparam logic [RES_CNT_W-1:0] RES_LIMIT = RES_CNT_W'(MAX_RESULTS);

   // Record stores
   logic [ID_W-1:0] id_store_ff    [MAX_PROCS];
   logic [NS-1:0]   rmask_store_ff [MAX_PROCS];
   logic [NS-1:0]   wmask_store_ff [MAX_PROCS];

   // Control state
   logic [CW-1:0]        load_cnt_ff, load_cnt_in;
   logic                 drop_ff, drop_in;
   logic [MAX_PROCS-1:0] marks_ff, marks_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        j_ff, j_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic                 pend_gend_ff, pend_gend_in;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [GRP_W-1:0]     grp_ff, grp_in;
   logic                 rsp_vld_ff, rsp_vld_in;

   // Payload state
   logic [IW-1:0]    eval_idx_ff;
   logic [ID_W-1:0]  rd_id_ff;
   logic [NS-1:0]    rd_rmask_ff;
   logic [NS-1:0]    rd_wmask_ff;
   logic [NS-1:0]    g_rd_ff, g_rd_in;
   logic [NS-1:0]    g_wr_ff, g_wr_in;
   logic [ID_W-1:0]  pend_id_ff, pend_id_in;
   logic [GRP_W-1:0] pend_grp_ff, pend_grp_in;
   rsp_type          rsp_ff, rsp_in;

   logic out_free;
   logic join_hit;
   logic stall;
   logic scan_step;
   logic rd_en;
   logic store_wr;

   assign out_free  = !rsp_vld_ff || rsp_ready;
   // Joins when unassigned and no read/write conflict with the group so far
   assign join_hit  = eval_vld_ff && !marks_ff[eval_idx_ff]
                      && ((rd_wmask_ff & (g_rd_ff | g_wr_ff)) == '0)
                      && ((g_wr_ff & rd_rmask_ff) == '0);
   assign stall     = join_hit && pend_vld_ff && !out_free;
   assign scan_step = cmd.scan && !stall;
   assign rd_en     = scan_step && (j_ff != load_cnt_ff);
   assign store_wr  = cmd.load && (load_cnt_ff != FULL_CNT);

   // Store write on load, registered read during scan
   always_ff @(posedge clock) begin
      if (store_wr) begin
         id_store_ff[load_cnt_ff[IW-1:0]]    <= req_data.proc_tag;
         rmask_store_ff[load_cnt_ff[IW-1:0]] <= req_data.read_mask[NS-1:0];
         wmask_store_ff[load_cnt_ff[IW-1:0]] <= req_data.write_mask[NS-1:0];
      end
      if (rd_en) begin
         rd_id_ff    <= id_store_ff[j_ff[IW-1:0]];
         rd_rmask_ff <= rmask_store_ff[j_ff[IW-1:0]];
         rd_wmask_ff <= wmask_store_ff[j_ff[IW-1:0]];
         eval_idx_ff <= j_ff[IW-1:0];
      end
   end

   // Next-state logic
   always_comb begin
      load_cnt_in  = load_cnt_ff;
      drop_in      = drop_ff;
      marks_in     = marks_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      eval_vld_in  = eval_vld_ff;
      pend_vld_in  = pend_vld_ff;
      pend_gend_in = pend_gend_ff;
      res_cnt_in   = res_cnt_ff;
      grp_in       = grp_ff;
      rsp_vld_in   = rsp_vld_ff;
      g_rd_in      = g_rd_ff;
      g_wr_in      = g_wr_ff;
      pend_id_in   = pend_id_ff;
      pend_grp_in  = pend_grp_ff;
      rsp_in       = rsp_ff;

      // Output register drains on handshake
      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end

      // Record load; overflow sets the drop flag
      if (cmd.load) begin
         if (load_cnt_ff == FULL_CNT) begin
            drop_in = 1'b1;
         end else begin
            load_cnt_in = load_cnt_ff + 1'b1;
         end
      end

      // Seed already assigned
      if (cmd.skip) begin
         i_in = i_ff + 1'b1;
      end

      // New partition: empty unions, scan from the seed
      if (cmd.open) begin
         g_rd_in     = '0;
         g_wr_in     = '0;
         j_in        = i_ff;
         eval_vld_in = 1'b0;
      end

      // One candidate per cycle while the output is not stalled
      if (scan_step) begin
         if (join_hit) begin
            marks_in[eval_idx_ff] = 1'b1;
            g_rd_in      = g_rd_ff | rd_rmask_ff;
            g_wr_in      = g_wr_ff | rd_wmask_ff;
            res_cnt_in   = res_cnt_ff + 1'b1;
            pend_id_in   = rd_id_ff;
            pend_grp_in  = grp_ff;
            pend_gend_in = 1'b0;
            pend_vld_in  = 1'b1;
            if (pend_vld_ff) begin
               rsp_in.group_id   = pend_grp_ff;
               rsp_in.member_id  = pend_id_ff;
               rsp_in.group_end  = pend_gend_ff;
               rsp_in.run_end    = 1'b0;
               rsp_in.overflowed = drop_ff;
               rsp_vld_in        = 1'b1;
            end
         end
         if (j_ff != load_cnt_ff) begin
            j_in        = j_ff + 1'b1;
            eval_vld_in = 1'b1;
         end else begin
            eval_vld_in = 1'b0;
         end
      end

      // Pending member closes its partition
      if (cmd.end_group) begin
         pend_gend_in = 1'b1;
         grp_in       = grp_ff + 1'b1;
         i_in         = i_ff + 1'b1;
      end

      // Final result out, then clear the run
      if (cmd.finish && out_free) begin
         if (pend_vld_ff) begin
            rsp_in.group_id   = pend_grp_ff;
            rsp_in.member_id  = pend_id_ff;
            rsp_in.group_end  = 1'b1;
            rsp_in.run_end    = 1'b1;
            rsp_in.overflowed = drop_ff;
            rsp_vld_in        = 1'b1;
         end
         load_cnt_in  = '0;
         drop_in      = 1'b0;
         marks_in     = '0;
         i_in         = '0;
         j_in         = '0;
         eval_vld_in  = 1'b0;
         pend_vld_in  = 1'b0;
         pend_gend_in = 1'b0;
         res_cnt_in   = '0;
         grp_in       = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff  <= '0;
         drop_ff      <= 1'b0;
         marks_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         eval_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         pend_gend_ff <= 1'b0;
         res_cnt_ff   <= '0;
         grp_ff       <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         load_cnt_ff  <= load_cnt_in;
         drop_ff      <= drop_in;
         marks_ff     <= marks_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         eval_vld_ff  <= eval_vld_in;
         pend_vld_ff  <= pend_vld_in;
         pend_gend_ff <= pend_gend_in;
         res_cnt_ff   <= res_cnt_in;
         grp_ff       <= grp_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      g_rd_ff     <= g_rd_in;
      g_wr_ff     <= g_wr_in;
      pend_id_ff  <= pend_id_in;
      pend_grp_ff <= pend_grp_in;
      rsp_ff      <= rsp_in;
   end

   // Status to the controller
   always_comb begin
      sts.i_done    = (i_ff == load_cnt_ff);
      sts.i_marked  = marks_ff[i_ff[IW-1:0]];
      sts.scan_done = (j_ff == load_cnt_ff) && !eval_vld_ff;
      sts.res_full  = (res_cnt_ff == RES_LIMIT);
      sts.out_free  = out_free;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `CFPG_ASSERT_IMPLY(a_gend_needs_pend, pend_gend_ff, pend_vld_ff, "group end flag without pending result")
   `CFPG_ASSERT_NEXT(a_join_sets_mark, scan_step && join_hit, marks_ff[$past(eval_idx_ff)], "joined process not marked")
   `CFPG_ASSERT_IMPLY(a_load_cnt_range, 1'b1, load_cnt_ff <= FULL_CNT, "load count beyond capacity")

endmodule

/* sv/conflict_free_process_grouper.sv */
// Conflict-free process grouper, top level.
// Input channel req_*: one process record per transaction (id, read mask, write mask,
// last flag). Records are taken one per cycle into a store of MAX_PROCS entries;
// records beyond capacity are dropped and the run's results carry overflowed = 1.
// Mask bits at or above NUM_SIGNALS are ignored.
// The record marked last starts grouping; req_ready stays low until the run's
// final result has been loaded into the output register.
// Grouping walks the stored records in load order: a seed already assigned is skipped;
// an open partition is opened, then each record from its seed to the last stored
// record is read from the store and checked, and then the partition is closed.
// Result channel rsp_*: one transaction per grouped process, partition by partition,
// with group_end on each partition's last member and run_end on the final one.
// At most 32 results per run are sent. A stalled receiver holds the scan in place;
// nothing is lost. Reset (synchronous, active high) empties the store and flags.
module conflict_free_process_grouper import cfpg_pkg::*; #(
   parameter int MAX_PROCS   = 32,
   parameter int NUM_SIGNALS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   cfpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_process),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Stores, scan and output
   cfpg_datapath #(
      .MAX_PROCS   (MAX_PROCS),
      .NUM_SIGNALS (NUM_SIGNALS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
